// ----- rtl/gtidp_pkg.sv -----
// Shared types and character constants for the identifier-set text parser.
// No dependencies.
package gtidp_pkg;

	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] LAST_FIELD = 2'd2;

	typedef enum logic [2:0] {
		PH_LEAD  = 3'b001,
		PH_FIELD = 3'b010,
		PH_TRAIL = 3'b100
	} phase_t;

endpackage

// ----- rtl/gtid_set_text_parser_unit.sv -----
// Identifier-set text parser top level: one character per transaction in, parsed
// domain-server-sequence triples out. Depends on gtidp_pkg.

// One character is taken per cycle. A character is held in an input register, the
// parse step (character class compare plus one times-ten accumulate with overflow
// check) runs between that register and the result register, and the result register
// drives the output. Sustained rate is one character per cycle while results are
// taken; a held result stalls the input only when the next character reaches the
// parse step. An entry is reported at its comma or at the end of the text; after an
// error the rest of the text is dropped and one error result closes the text.
// Entries reported before an error stay reported.
module gtid_set_text_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_of_text,
	input  logic        empty_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        entry_valid,
	output logic [31:0] domain_value,
	output logic [31:0] server_value,
	output logic [63:0] sequence_value,
	output logic        status,
	output logic        set_done
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       empty_s1;
	logic       advance;

	gtidp_pkg::phase_t phase_q, phase_n, phase_c;
	logic [1:0]  field_q, field_n, field_b;
	logic        seen_q, seen_n;
	logic        err_q, err_n;
	logic [31:0] dom_q, dom_n;
	logic [31:0] srv_q, srv_n;
	logic [63:0] seq_q, seq_n;

	logic        emit;
	logic        emit_entry;
	logic        emit_status;
	logic        emit_done;
	logic        is_end;
	logic        ready_c;
	logic [63:0] base;
	logic [67:0] prod;
	logic        ovf;
	logic [3:0]  digit;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1  <= char_byte;
			end_s1   <= end_of_text;
			empty_s1 <= empty_text;
		end
	end

	always_comb begin
		case (phase_q)
			gtidp_pkg::PH_FIELD: phase_c = gtidp_pkg::PH_FIELD;
			gtidp_pkg::PH_TRAIL: phase_c = gtidp_pkg::PH_TRAIL;
			default:             phase_c = gtidp_pkg::PH_LEAD;
		endcase
	end

	always_comb begin
		digit   = 4'(char_s1 - gtidp_pkg::CH_ZERO);
		field_b = (phase_c == gtidp_pkg::PH_LEAD) ? 2'd0 : field_q;
		if (phase_c == gtidp_pkg::PH_LEAD) begin
			base = 64'd0;
		end else if (field_q == 2'd0) begin
			base = {32'd0, dom_q};
		end else if (field_q == 2'd1) begin
			base = {32'd0, srv_q};
		end else begin
			base = seq_q;
		end
		prod = ({4'd0, base} << 3) + ({4'd0, base} << 1) + {64'd0, digit};
		ovf  = (field_b == gtidp_pkg::LAST_FIELD) ? (prod[67:64] != 4'd0)
		                                          : (prod[67:32] != 36'd0);
	end

	always_comb begin
		phase_n = phase_c;
		field_n = field_q;
		seen_n  = seen_q;
		err_n   = err_q;
		dom_n   = dom_q;
		srv_n   = srv_q;
		seq_n   = seq_q;
		ready_c = 1'b0;
		if (!empty_s1 && !err_q) begin
			if (char_s1 == gtidp_pkg::CH_COMMA) begin
				if (phase_c != gtidp_pkg::PH_LEAD) begin
					if (field_q == gtidp_pkg::LAST_FIELD && seen_q) begin
						phase_n = gtidp_pkg::PH_LEAD;
						ready_c = 1'b1;
					end else begin
						err_n = 1'b1;
					end
				end
			end else if (char_s1 inside {gtidp_pkg::CH_SPACE, gtidp_pkg::CH_TAB,
					gtidp_pkg::CH_LF, gtidp_pkg::CH_CR}) begin
				if (phase_c == gtidp_pkg::PH_FIELD) begin
					phase_n = gtidp_pkg::PH_TRAIL;
				end
			end else if (phase_c == gtidp_pkg::PH_TRAIL) begin
				err_n = 1'b1;
			end else if (char_s1 inside {[gtidp_pkg::CH_ZERO:gtidp_pkg::CH_NINE]}) begin
				phase_n = gtidp_pkg::PH_FIELD;
				field_n = field_b;
				seen_n  = 1'b1;
				if (phase_c == gtidp_pkg::PH_LEAD) begin
					dom_n = 32'd0;
					srv_n = 32'd0;
					seq_n = 64'd0;
				end
				if (ovf) begin
					err_n = 1'b1;
				end else if (field_b == 2'd0) begin
					dom_n = prod[31:0];
				end else if (field_b == 2'd1) begin
					srv_n = prod[31:0];
				end else begin
					seq_n = prod[63:0];
				end
			end else if (char_s1 == gtidp_pkg::CH_DASH && phase_c == gtidp_pkg::PH_FIELD
					&& seen_q && field_q < gtidp_pkg::LAST_FIELD) begin
				field_n = field_q + 2'd1;
				seen_n  = 1'b0;
			end else begin
				err_n = 1'b1;
			end
		end
	end

	always_comb begin
		is_end      = end_s1 || empty_s1;
		emit        = ready_c || is_end;
		emit_done   = is_end;
		emit_entry  = 1'b0;
		emit_status = 1'b0;
		if (!is_end) begin
			emit_entry = ready_c;
		end else if (err_n) begin
			emit_status = 1'b1;
		end else if (ready_c) begin
			emit_entry = 1'b1;
		end else if (phase_n == gtidp_pkg::PH_LEAD) begin
			emit_entry = 1'b0;
		end else if (field_n == gtidp_pkg::LAST_FIELD && seen_n) begin
			emit_entry = 1'b1;
		end else begin
			emit_status = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gtidp_pkg::PH_LEAD;
			field_q <= 2'd0;
			seen_q  <= 1'b0;
			err_q   <= 1'b0;
			dom_q   <= 32'd0;
			srv_q   <= 32'd0;
			seq_q   <= 64'd0;
		end else if (advance) begin
			if (is_end) begin
				phase_q <= gtidp_pkg::PH_LEAD;
				field_q <= 2'd0;
				seen_q  <= 1'b0;
				err_q   <= 1'b0;
				dom_q   <= 32'd0;
				srv_q   <= 32'd0;
				seq_q   <= 64'd0;
			end else begin
				phase_q <= phase_n;
				field_q <= field_n;
				seen_q  <= seen_n;
				err_q   <= err_n;
				dom_q   <= dom_n;
				srv_q   <= srv_n;
				seq_q   <= seq_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			entry_valid    <= emit_entry;
			domain_value   <= emit_entry ? dom_n : 32'd0;
			server_value   <= emit_entry ? srv_n : 32'd0;
			sequence_value <= emit_entry ? seq_n : 64'd0;
			status         <= emit_status;
			set_done       <= emit_done;
		end
	end

endmodule

// ----- rtl/gtidp_checker.sv -----
// Port-level checker for the identifier-set text parser, bound to the top level.
// Depends on gtid_set_text_parser_unit.
module gtidp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        entry_valid,
	input logic [31:0] domain_value,
	input logic [31:0] server_value,
	input logic [63:0] sequence_value,
	input logic        status,
	input logic        set_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_valid)
			&& $stable(domain_value) && $stable(server_value)
			&& $stable(sequence_value) && $stable(status) && $stable(set_done))
		else $error("result transaction changed while stalled");

	a_err_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> set_done && !entry_valid)
		else $error("error result does not close the text");

	a_zero_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> domain_value == 32'd0 && server_value == 32'd0
			&& sequence_value == 64'd0)
		else $error("non-entry result carries values");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted character");

endmodule

bind gtid_set_text_parser_unit gtidp_checker u_gtidp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.entry_valid    (entry_valid),
	.domain_value   (domain_value),
	.server_value   (server_value),
	.sequence_value (sequence_value),
	.status         (status),
	.set_done       (set_done)
);
